@@ hw/rtl/lsse_pkg.sv @@
// Shared types, constants and decode helpers for the line sensor steering error block.
// No dependencies; every other file refers to this package by scoped names.
package lsse_pkg;

    localparam int Channels = 10;
    localparam int ErrW     = 9;
    localparam int SumW     = 11;
    localparam int CountW   = 4;
    localparam int RightW   = 3;
    localparam int LimitW   = 8;
    localparam int ThreshW  = 4;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 9;

    // Index of the first channel at position zero or to its right.
    localparam int RightFirst = 4;

    localparam logic [CfgIdxW-1:0] REG_LOSS_LIMIT       = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_SEARCH_ERROR     = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_CORNER_FAR_ERROR = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_CORNER_THRESHOLD = 8'd3;

    localparam logic [LimitW-1:0]       LOSS_LIMIT_RST  = 8'd3;
    localparam logic signed [ErrW-1:0]  SEARCH_ERR_RST  = 9'sd120;
    localparam logic signed [ErrW-1:0]  CORNER_FAR_RST  = 9'sd255;
    localparam logic [ThreshW-1:0]      CORNER_THR_RST  = 4'd3;
    localparam logic [LimitW-1:0]       LOSS_COUNT_MAX  = 8'd255;

    typedef enum logic [2:0] {
        ST_TRACK  = 3'd0,
        ST_HOLD   = 3'd1,
        ST_SEARCH = 3'd2,
        ST_CORNER = 3'd3,
        ST_SPLIT  = 3'd4,
        ST_WIDE   = 3'd5
    } status_t;

    typedef struct packed {
        logic [LimitW-1:0]      loss_limit;
        logic signed [ErrW-1:0] search_error;
        logic signed [ErrW-1:0] corner_far_error;
        logic [ThreshW-1:0]     corner_threshold;
    } cfg_t;

    typedef struct packed {
        logic signed [ErrW-1:0] last_error;
        logic [LimitW-1:0]      loss_count;
        logic                   tracking;
    } track_state_t;

    typedef struct packed {
        logic signed [ErrW-1:0] err;
        status_t                status;
        logic                   state_write;
        track_state_t           state_next;
    } decision_t;

    typedef logic signed [5:0] pos_t;

    localparam pos_t POS [Channels] = '{
        -6'sd8, -6'sd6, -6'sd4, -6'sd2, 6'sd0, 6'sd0, 6'sd2, 6'sd4, 6'sd6, 6'sd8
    };

    // sign(x) * (2x^2 + 3|x|); the two center channels weigh -1 and +1.
    localparam logic signed [ErrW-1:0] WEIGHT [Channels] = '{
        -9'sd152, -9'sd90, -9'sd44, -9'sd14, -9'sd1,
        9'sd1, 9'sd14, 9'sd44, 9'sd90, 9'sd152
    };

    // True when exactly two channels are lit and their positions differ by two.
    function automatic logic is_adjacent_pair(input logic [Channels-1:0] bits);
        logic hit;
        pos_t d;
        hit = 1'b0;
        for (int i = 0; i < Channels; i++) begin
            for (int j = i + 1; j < Channels; j++) begin
                d = POS[j] - POS[i];
                if ((d == 6'sd2) &&
                    (bits == ((Channels'(1) << i) | (Channels'(1) << j)))) begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

endpackage

@@ hw/rtl/lsse_core.sv @@
// Combinational decision logic: weights, counts and the rule chain for one sample.
// Depends on lsse_pkg.
module lsse_core (
    input  logic [lsse_pkg::Channels-1:0] sensor_bits,
    input  lsse_pkg::cfg_t                cfg,
    input  lsse_pkg::track_state_t        state,
    output lsse_pkg::decision_t           dec
);

    logic signed [lsse_pkg::SumW-1:0]  left_sum;
    logic signed [lsse_pkg::SumW-1:0]  right_sum;
    logic signed [lsse_pkg::SumW-1:0]  sum;
    logic signed [lsse_pkg::SumW-1:0]  half_sum;
    logic [lsse_pkg::CountW-1:0]       hit_count;
    logic [lsse_pkg::RightW-1:0]       right_count;
    logic                              adjacent;
    logic [lsse_pkg::LimitW-1:0]       loss_inc;

    // Two short partial sums keep the adder chain shallow.
    always_comb begin
        left_sum  = '0;
        right_sum = '0;
        for (int i = 0; i < lsse_pkg::Channels / 2; i++) begin
            if (sensor_bits[i]) begin
                left_sum = left_sum + lsse_pkg::SumW'(lsse_pkg::WEIGHT[i]);
            end
        end
        for (int i = lsse_pkg::Channels / 2; i < lsse_pkg::Channels; i++) begin
            if (sensor_bits[i]) begin
                right_sum = right_sum + lsse_pkg::SumW'(lsse_pkg::WEIGHT[i]);
            end
        end
    end

    assign sum         = left_sum + right_sum;
    assign half_sum    = sum >>> 1;
    assign hit_count   = lsse_pkg::CountW'($countones(sensor_bits));
    assign right_count = lsse_pkg::RightW'($countones(
                             sensor_bits[lsse_pkg::Channels-1:lsse_pkg::RightFirst]));
    assign adjacent    = lsse_pkg::is_adjacent_pair(sensor_bits);
    assign loss_inc    = (state.loss_count == lsse_pkg::LOSS_COUNT_MAX) ?
                         state.loss_count : state.loss_count + 1'b1;

    always_comb begin
        dec.err         = '0;
        dec.status      = lsse_pkg::ST_TRACK;
        dec.state_write = 1'b1;
        dec.state_next  = state;

        if (hit_count == '0) begin
            dec.state_next.loss_count = loss_inc;
            dec.state_next.tracking   = 1'b0;
            if (loss_inc >= cfg.loss_limit) begin
                dec.err    = cfg.search_error;
                dec.status = lsse_pkg::ST_SEARCH;
            end else begin
                dec.err    = state.last_error;
                dec.status = lsse_pkg::ST_HOLD;
            end
        end else begin
            if ({1'b0, right_count} >= cfg.corner_threshold) begin
                dec.err    = sensor_bits[lsse_pkg::Channels-1] ?
                             cfg.corner_far_error : cfg.search_error;
                dec.status = lsse_pkg::ST_CORNER;
            end else if (hit_count == 4'd1) begin
                dec.err    = sum[lsse_pkg::ErrW-1:0];
                dec.status = lsse_pkg::ST_TRACK;
            end else if (hit_count == 4'd2) begin
                if (adjacent) begin
                    dec.err    = half_sum[lsse_pkg::ErrW-1:0];
                    dec.status = lsse_pkg::ST_TRACK;
                end else begin
                    // A split pair is reported but leaves the tracking state alone.
                    dec.err         = '0;
                    dec.status      = lsse_pkg::ST_SPLIT;
                    dec.state_write = 1'b0;
                end
            end else begin
                dec.err    = '0;
                dec.status = lsse_pkg::ST_WIDE;
            end
            if (!state.tracking) begin
                dec.state_next.loss_count = '0;
                dec.state_next.tracking   = 1'b1;
            end
            dec.state_next.last_error = dec.err;
        end
    end

endmodule

@@ hw/rtl/line_sensor_steering_error_top.sv @@
// An accepted sample goes from the input register through lsse_core to the result register.
// Throughput: one sample per cycle while results are taken. While a result waits to be taken,
// the input register takes one more transaction and then holds s_ready low until the result leaves.
// Reset (aresetn, synchronous, active low) empties both registers, clears the last
// error, loss count and tracking flag, and loads the configuration reset values.
// Top level: input and result registers, configuration and tracking state; uses lsse_core.
module line_sensor_steering_error_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lsse_pkg::Channels-1:0]        s_sensor_bits,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lsse_pkg::ErrW-1:0]     m_steering_error,
    output logic [2:0]                           m_line_status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lsse_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [lsse_pkg::CfgDataW-1:0]        cfg_data
);

    logic                               in_valid_reg;
    logic [lsse_pkg::Channels-1:0]      in_bits_reg;
    logic                               out_valid_reg;
    logic signed [lsse_pkg::ErrW-1:0]   out_err_reg;
    lsse_pkg::status_t                  out_status_reg;
    lsse_pkg::cfg_t                     cfg_reg;
    lsse_pkg::track_state_t             state_reg;
    lsse_pkg::decision_t                dec;
    logic                               advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    lsse_core u_core (
        .sensor_bits (in_bits_reg),
        .cfg         (cfg_reg),
        .state       (state_reg),
        .dec         (dec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_bits_reg <= s_sensor_bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                if (dec.state_write) begin
                    state_reg <= dec.state_next;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            out_err_reg    <= dec.err;
            out_status_reg <= dec.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.loss_limit       <= lsse_pkg::LOSS_LIMIT_RST;
            cfg_reg.search_error     <= lsse_pkg::SEARCH_ERR_RST;
            cfg_reg.corner_far_error <= lsse_pkg::CORNER_FAR_RST;
            cfg_reg.corner_threshold <= lsse_pkg::CORNER_THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lsse_pkg::REG_LOSS_LIMIT: begin
                    cfg_reg.loss_limit <= cfg_data[lsse_pkg::LimitW-1:0];
                end
                lsse_pkg::REG_SEARCH_ERROR: begin
                    cfg_reg.search_error <= cfg_data[lsse_pkg::ErrW-1:0];
                end
                lsse_pkg::REG_CORNER_FAR_ERROR: begin
                    cfg_reg.corner_far_error <= cfg_data[lsse_pkg::ErrW-1:0];
                end
                lsse_pkg::REG_CORNER_THRESHOLD: begin
                    cfg_reg.corner_threshold <= cfg_data[lsse_pkg::ThreshW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_steering_error = out_err_reg;
    assign m_line_status    = out_status_reg;

    // A split pair must leave the tracking state untouched.
    a_split_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && dec.status == lsse_pkg::ST_SPLIT) |=> $stable(state_reg))
        else $error("tracking state changed on a split pair");

    // The loss count only moves up by one, stays, or returns to zero.
    a_loss_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(state_reg.loss_count) |->
            (state_reg.loss_count == '0) ||
            (state_reg.loss_count == $past(state_reg.loss_count) + 1'b1))
        else $error("loss count moved by an illegal step");

    // A hit that is not a split pair always leaves the tracking flag set.
    a_hit_sets_tracking: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && dec.status != lsse_pkg::ST_SPLIT && dec.status != lsse_pkg::ST_HOLD &&
         dec.status != lsse_pkg::ST_SEARCH) |=> state_reg.tracking)
        else $error("tracking flag not set after a hit");

    // An empty sample always clears the tracking flag.
    a_empty_clears_tracking: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_bits_reg == '0) |=> !state_reg.tracking)
        else $error("tracking flag still set after an empty sample");

endmodule
